>>> src/stt_pkg.sv
// source text tokenizer package: request and result structs, queue entry,
// token kind and error codes shared by the front, queue, back and top level
// no dependencies
`default_nettype none

package stt_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  value_byte;
        logic [5:0]  token_kind;
        logic [2:0]  error_code;
        logic [31:0] begin_pos;
        logic [31:0] end_pos;
        logic        last;
    } t_out;

    // one or two results caused by a single request
    typedef struct packed {
        logic two;
        t_out r0;
        t_out r1;
    } t_qent;

    localparam logic RK_VALUE = 1'b0;
    localparam logic RK_TOKEN = 1'b1;

    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_ID       = 6'd1;
    localparam logic [5:0] K_INT      = 6'd2;
    localparam logic [5:0] K_FLOAT    = 6'd3;
    localparam logic [5:0] K_STR      = 6'd4;
    localparam logic [5:0] K_ADD      = 6'd5;
    localparam logic [5:0] K_SUB      = 6'd6;
    localparam logic [5:0] K_MUL      = 6'd7;
    localparam logic [5:0] K_DIV      = 6'd8;
    localparam logic [5:0] K_CARET    = 6'd9;
    localparam logic [5:0] K_LPAREN   = 6'd10;
    localparam logic [5:0] K_RPAREN   = 6'd11;
    localparam logic [5:0] K_NEWLINE  = 6'd12;
    localparam logic [5:0] K_COMMA    = 6'd13;
    localparam logic [5:0] K_SEMI     = 6'd14;
    localparam logic [5:0] K_LSQB     = 6'd15;
    localparam logic [5:0] K_RSQB     = 6'd16;
    localparam logic [5:0] K_LCURLY   = 6'd17;
    localparam logic [5:0] K_RCURLY   = 6'd18;
    localparam logic [5:0] K_DOT      = 6'd19;
    localparam logic [5:0] K_COLON    = 6'd20;
    localparam logic [5:0] K_ASSIGN   = 6'd21;
    localparam logic [5:0] K_EQ       = 6'd22;
    localparam logic [5:0] K_NOT      = 6'd23;
    localparam logic [5:0] K_NE       = 6'd24;
    localparam logic [5:0] K_LT       = 6'd25;
    localparam logic [5:0] K_LE       = 6'd26;
    localparam logic [5:0] K_GT       = 6'd27;
    localparam logic [5:0] K_GE       = 6'd28;
    localparam logic [5:0] K_AND      = 6'd29;
    localparam logic [5:0] K_LAND     = 6'd30;
    localparam logic [5:0] K_OR       = 6'd31;
    localparam logic [5:0] K_LOR      = 6'd32;
    localparam logic [5:0] K_ARROW    = 6'd33;
    localparam logic [5:0] K_RANGE    = 6'd34;
    localparam logic [5:0] K_ELLIPSIS = 6'd35;
    localparam logic [5:0] K_ERR      = 6'd36;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_BAD_CHAR = 3'd1;
    localparam logic [2:0] E_UNDERSC  = 3'd2;
    localparam logic [2:0] E_EXP_SIGN = 3'd3;
    localparam logic [2:0] E_UNCLOSED = 3'd4;
    localparam logic [2:0] E_ESCAPE   = 3'd5;

endpackage

`default_nettype wire

>>> src/stt_front.sv
// tokenizer front end: lexer state machine, classifies each byte and
// pushes the one or two results it causes into the result queue
// depends on stt_pkg
`default_nettype none

module stt_front
    import stt_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_data,
    output logic      o_stall,
    input  wire logic i_full,
    output logic      o_push,
    output t_qent     o_push_data
);

    localparam logic [4:0] M_START      = 5'd0;
    localparam logic [4:0] M_COMMENT    = 5'd1;
    localparam logic [4:0] M_ID         = 5'd2;
    localparam logic [4:0] M_ID_US      = 5'd3;
    localparam logic [4:0] M_WHOLE      = 5'd4;
    localparam logic [4:0] M_FRAC_START = 5'd5;
    localparam logic [4:0] M_FRAC       = 5'd6;
    localparam logic [4:0] M_EXP_START  = 5'd7;
    localparam logic [4:0] M_EXP_SIGN   = 5'd8;
    localparam logic [4:0] M_EXP        = 5'd9;
    localparam logic [4:0] M_STR        = 5'd10;
    localparam logic [4:0] M_STR_ESC    = 5'd11;
    localparam logic [4:0] M_OP_EQ      = 5'd12;
    localparam logic [4:0] M_OP_NOT     = 5'd13;
    localparam logic [4:0] M_OP_LT      = 5'd14;
    localparam logic [4:0] M_OP_GT      = 5'd15;
    localparam logic [4:0] M_OP_AMP     = 5'd16;
    localparam logic [4:0] M_OP_BAR     = 5'd17;
    localparam logic [4:0] M_OP_MINUS   = 5'd18;
    localparam logic [4:0] M_DOT        = 5'd19;
    localparam logic [4:0] M_DOT2       = 5'd20;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_US     = 8'h5f;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;

    logic [4:0]           r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [POS_WIDTH-1:0] r_tok, n_tok;
    logic                 r_flt, n_flt;
    logic [POS_WIDTH-1:0] w_p1;
    logic                 w_accept;

    function automatic t_out f_fin(input logic [5:0] tk, input logic [2:0] ec,
                                   input logic [POS_WIDTH-1:0] s,
                                   input logic [POS_WIDTH-1:0] e);
        t_out                 r;
        logic [POS_WIDTH-1:0] ee;
        logic [63:0]          ws;
        logic [63:0]          we;
        ee = (e == s) ? e + 1'b1 : e;
        ws = 64'(s);
        we = 64'(ee);
        r.result_kind = RK_TOKEN;
        r.value_byte  = 8'h00;
        r.token_kind  = tk;
        r.error_code  = ec;
        r.begin_pos   = ws[31:0];
        r.end_pos     = we[31:0];
        r.last        = 1'b0;
        return r;
    endfunction

    // value byte: end is the offset just after the byte
    function automatic t_out f_val(input logic [7:0] b, input logic [5:0] tk,
                                   input logic [POS_WIDTH-1:0] s,
                                   input logic [POS_WIDTH-1:0] e);
        t_out        r;
        logic [63:0] ws;
        logic [63:0] we;
        ws = 64'(s);
        we = 64'(e);
        r.result_kind = RK_VALUE;
        r.value_byte  = b;
        r.token_kind  = tk;
        r.error_code  = E_NONE;
        r.begin_pos   = ws[31:0];
        r.end_pos     = we[31:0];
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] f_op_second(input logic [4:0] m);
        logic [7:0] r;
        case (m)
            M_OP_AMP:   r = "&";
            M_OP_BAR:   r = "|";
            M_OP_MINUS: r = ">";
            default:    r = "=";
        endcase
        return r;
    endfunction

    function automatic logic [5:0] f_op_long(input logic [4:0] m);
        logic [5:0] r;
        case (m)
            M_OP_EQ:    r = K_EQ;
            M_OP_NOT:   r = K_NE;
            M_OP_LT:    r = K_LE;
            M_OP_GT:    r = K_GE;
            M_OP_AMP:   r = K_LAND;
            M_OP_BAR:   r = K_LOR;
            default:    r = K_ARROW;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] f_op_short(input logic [4:0] m);
        logic [5:0] r;
        case (m)
            M_OP_EQ:    r = K_ASSIGN;
            M_OP_NOT:   r = K_NOT;
            M_OP_LT:    r = K_LT;
            M_OP_GT:    r = K_GT;
            M_OP_AMP:   r = K_AND;
            M_OP_BAR:   r = K_OR;
            default:    r = K_SUB;
        endcase
        return r;
    endfunction

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_p1     = r_pos + 1'b1;

    always_comb begin
        logic [7:0] c;
        logic       letter;
        logic       digit;
        logic [5:0] nk;
        logic [4:0] sb_mode;
        logic       sb_flt;
        logic       sb_v;
        t_out       sb_r;
        logic       a_v;
        t_out       a_r;
        logic       b_v;
        t_out       b_r;
        logic       go_start;
        t_qent      q;

        c      = i_data.ch;
        letter = (c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h80:8'hff]});
        digit  = (c inside {[8'h30:8'h39]});
        nk     = r_flt ? K_FLOAT : K_INT;

        // byte handled in the start mode, token begins here
        sb_mode = M_START;
        sb_flt  = r_flt;
        sb_v    = 1'b0;
        sb_r    = f_fin(K_ERR, E_BAD_CHAR, r_pos, w_p1);
        case (c) inside
            "=": sb_mode = M_OP_EQ;
            "!": sb_mode = M_OP_NOT;
            "<": sb_mode = M_OP_LT;
            ">": sb_mode = M_OP_GT;
            "&": sb_mode = M_OP_AMP;
            "|": sb_mode = M_OP_BAR;
            "-": sb_mode = M_OP_MINUS;
            CH_HASH: sb_mode = M_COMMENT;
            [8'h61:8'h7a], [8'h41:8'h5a], [8'h80:8'hff]: begin
                sb_mode = M_ID;
                sb_v    = 1'b1;
                sb_r    = f_val(c, K_ID, r_pos, w_p1);
            end
            CH_US: begin
                sb_mode = M_ID_US;
                sb_v    = 1'b1;
                sb_r    = f_val(c, K_ID, r_pos, w_p1);
            end
            [8'h30:8'h39]: begin
                sb_mode = M_WHOLE;
                sb_flt  = 1'b0;
                sb_v    = 1'b1;
                sb_r    = f_val(c, K_INT, r_pos, w_p1);
            end
            CH_QUOTE: sb_mode = M_STR;
            ".": sb_mode = M_DOT;
            " ", CH_TAB: sb_v = 1'b0;
            "+":   begin sb_v = 1'b1; sb_r = f_fin(K_ADD, E_NONE, r_pos, w_p1);     end
            "*":   begin sb_v = 1'b1; sb_r = f_fin(K_MUL, E_NONE, r_pos, w_p1);     end
            "/":   begin sb_v = 1'b1; sb_r = f_fin(K_DIV, E_NONE, r_pos, w_p1);     end
            "^":   begin sb_v = 1'b1; sb_r = f_fin(K_CARET, E_NONE, r_pos, w_p1);   end
            "(":   begin sb_v = 1'b1; sb_r = f_fin(K_LPAREN, E_NONE, r_pos, w_p1);  end
            ")":   begin sb_v = 1'b1; sb_r = f_fin(K_RPAREN, E_NONE, r_pos, w_p1);  end
            CH_LF: begin sb_v = 1'b1; sb_r = f_fin(K_NEWLINE, E_NONE, r_pos, w_p1); end
            ",":   begin sb_v = 1'b1; sb_r = f_fin(K_COMMA, E_NONE, r_pos, w_p1);   end
            ";":   begin sb_v = 1'b1; sb_r = f_fin(K_SEMI, E_NONE, r_pos, w_p1);    end
            "[":   begin sb_v = 1'b1; sb_r = f_fin(K_LSQB, E_NONE, r_pos, w_p1);    end
            "]":   begin sb_v = 1'b1; sb_r = f_fin(K_RSQB, E_NONE, r_pos, w_p1);    end
            "{":   begin sb_v = 1'b1; sb_r = f_fin(K_LCURLY, E_NONE, r_pos, w_p1);  end
            "}":   begin sb_v = 1'b1; sb_r = f_fin(K_RCURLY, E_NONE, r_pos, w_p1);  end
            ":":   begin sb_v = 1'b1; sb_r = f_fin(K_COLON, E_NONE, r_pos, w_p1);   end
            default: sb_v = 1'b1;
        endcase

        n_mode   = r_mode;
        n_tok    = r_tok;
        n_flt    = r_flt;
        n_pos    = w_p1;
        a_v      = 1'b0;
        a_r      = f_val(c, K_ID, r_tok, w_p1);
        b_v      = 1'b0;
        b_r      = sb_r;
        go_start = 1'b0;

        if (i_data.end_of_input) begin
            // flush the pending token, then eof at the current offset
            n_pos = r_pos;
            a_v   = 1'b1;
            case (r_mode) inside
                M_ID, M_ID_US:      a_r = f_fin(K_ID, E_NONE, r_tok, r_pos);
                M_EXP_SIGN:         a_r = f_fin(K_ERR, E_EXP_SIGN, r_tok, r_pos);
                [M_WHOLE:M_EXP]:    a_r = f_fin(nk, E_NONE, r_tok, r_pos);
                M_STR, M_STR_ESC:   a_r = f_fin(K_ERR, E_UNCLOSED, r_tok, r_pos);
                [M_OP_EQ:M_OP_MINUS]:
                    a_r = f_fin(f_op_short(r_mode), E_NONE, r_tok, r_pos);
                M_DOT:              a_r = f_fin(K_DOT, E_NONE, r_tok, r_pos);
                M_DOT2:             a_r = f_fin(K_RANGE, E_NONE, r_tok, r_pos);
                default:            a_v = 1'b0;
            endcase
            n_mode = M_START;
            b_v    = 1'b1;
            b_r    = f_fin(K_EOF, E_NONE, r_pos, r_pos);
            b_r.end_pos = 32'(64'(w_p1));
        end else begin
            case (r_mode) inside
                M_COMMENT: go_start = (c == CH_LF);
                M_ID: begin
                    a_v = 1'b1;
                    if (letter || digit || c == CH_US) begin
                        a_r = f_val(c, K_ID, r_tok, w_p1);
                    end else begin
                        a_r      = f_fin(K_ID, E_NONE, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                M_ID_US: begin
                    a_v = 1'b1;
                    if (c == CH_US || digit) begin
                        a_r    = f_fin(K_ERR, E_UNDERSC, r_tok, w_p1);
                        n_mode = M_START;
                    end else if (letter) begin
                        n_mode = M_ID;
                        a_r    = f_val(c, K_ID, r_tok, w_p1);
                    end else begin
                        a_r      = f_fin(K_ID, E_NONE, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                M_WHOLE, M_FRAC_START, M_FRAC, M_EXP_START, M_EXP: begin
                    a_v = 1'b1;
                    if (digit) begin
                        if (r_mode == M_FRAC_START) begin
                            n_mode = M_FRAC;
                        end else if (r_mode == M_EXP_START) begin
                            n_mode = M_EXP;
                        end
                        a_r = f_val(c, nk, r_tok, w_p1);
                    end else if (r_mode == M_WHOLE && c == ".") begin
                        n_mode = M_FRAC_START;
                        n_flt  = 1'b1;
                        a_r    = f_val(c, K_FLOAT, r_tok, w_p1);
                    end else if ((r_mode == M_WHOLE || r_mode == M_FRAC) && c == CH_E) begin
                        n_mode = M_EXP_START;
                        n_flt  = 1'b1;
                        a_r    = f_val(c, K_FLOAT, r_tok, w_p1);
                    end else if (r_mode == M_EXP_START && (c == "+" || c == "-")) begin
                        n_mode = M_EXP_SIGN;
                        a_r    = f_val(c, K_FLOAT, r_tok, w_p1);
                    end else begin
                        a_r      = f_fin(nk, E_NONE, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                M_EXP_SIGN: begin
                    a_v = 1'b1;
                    if (digit) begin
                        n_mode = M_EXP;
                        a_r    = f_val(c, nk, r_tok, w_p1);
                    end else begin
                        a_r      = f_fin(K_ERR, E_EXP_SIGN, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_BSLASH) begin
                        n_mode = M_STR_ESC;
                    end else if (c == CH_QUOTE) begin
                        a_v    = 1'b1;
                        a_r    = f_fin(K_STR, E_NONE, r_tok, w_p1);
                        n_mode = M_START;
                    end else begin
                        a_v = 1'b1;
                        a_r = f_val(c, K_STR, r_tok, w_p1);
                    end
                end
                M_STR_ESC: begin
                    a_v    = 1'b1;
                    n_mode = M_STR;
                    if (c == CH_BSLASH) begin
                        a_r = f_val(CH_BSLASH, K_STR, r_tok, w_p1);
                    end else if (c == "n") begin
                        a_r = f_val(CH_LF, K_STR, r_tok, w_p1);
                    end else if (c == "r") begin
                        a_r = f_val(CH_CR, K_STR, r_tok, w_p1);
                    end else begin
                        a_r    = f_fin(K_ERR, E_ESCAPE, r_tok, w_p1);
                        n_mode = M_START;
                    end
                end
                M_DOT: begin
                    if (c == ".") begin
                        n_mode = M_DOT2;
                    end else begin
                        a_v      = 1'b1;
                        a_r      = f_fin(K_DOT, E_NONE, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                M_DOT2: begin
                    a_v = 1'b1;
                    if (c == ".") begin
                        a_r    = f_fin(K_ELLIPSIS, E_NONE, r_tok, w_p1);
                        n_mode = M_START;
                    end else begin
                        a_r      = f_fin(K_RANGE, E_NONE, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                [M_OP_EQ:M_OP_MINUS]: begin
                    a_v = 1'b1;
                    if (c == f_op_second(r_mode)) begin
                        a_r    = f_fin(f_op_long(r_mode), E_NONE, r_tok, w_p1);
                        n_mode = M_START;
                    end else begin
                        a_r      = f_fin(f_op_short(r_mode), E_NONE, r_tok, r_pos);
                        go_start = 1'b1;
                    end
                end
                default: go_start = 1'b1;
            endcase

            // lookahead end: the byte is taken again in the start mode
            if (go_start) begin
                n_mode = sb_mode;
                n_tok  = r_pos;
                n_flt  = sb_flt;
                b_v    = sb_v;
            end
        end

        q.two = a_v && b_v;
        q.r0  = a_v ? a_r : b_r;
        q.r1  = b_r;
        q.r0.last = !(a_v && b_v);
        q.r1.last = 1'b1;
        o_push      = w_accept && (a_v || b_v);
        o_push_data = q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_pos  <= '0;
            r_tok  <= '0;
            r_flt  <= 1'b0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_tok  <= n_tok;
            r_flt  <= n_flt;
        end
    end

endmodule

`default_nettype wire

>>> src/stt_queue.sv
// small result queue between the tokenizer front and back ends
// one entry holds the results of one request; depends on stt_pkg
`default_nettype none

module stt_queue
    import stt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_push_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_qent      o_head,
    output logic       o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_qent         r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/stt_back.sv
// tokenizer back end: drains queue entries and sends their results out
// one per cycle while the output is not stalled, through an output register; depends on stt_pkg
`default_nettype none

module stt_back
    import stt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_qent i_head,
    output logic       o_pop,
    output logic       o_valid,
    output t_out       o_data,
    input  wire logic  i_stall
);

    logic r_ov;
    t_out r_out;
    logic r_pv;
    t_out r_pend;
    logic w_free;

    assign w_free  = !r_ov || !i_stall;
    // second result of an entry goes out before the next entry is taken
    assign o_pop   = w_free && !r_pv && !i_empty;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_pv) begin
                r_out <= r_pend;
            end else if (!i_empty) begin
                r_out  <= i_head.r0;
                r_pend <= i_head.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else if (w_free) begin
            if (r_pv) begin
                r_ov <= 1'b1;
                r_pv <= 1'b0;
            end else if (!i_empty) begin
                r_ov <= 1'b1;
                r_pv <= i_head.two;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/source_text_tokenizer.sv
// Streaming tokenizer: takes one source byte per request and gives value bytes and
// completed tokens with kind, error code and positions. A byte is taken every cycle
// while the result queue (QUEUE_DEPTH entries, one per byte that gives results) has
// room; each byte gives zero, one or two results, and the output register sends one
// result per cycle while i_stall is low, so the sustained byte rate is one per cycle
// for text that averages at most one result per byte and is otherwise set by the
// result count. A result passes through the queue memory and then the output register.
// Positions count in POS_WIDTH bits and show as their low 32 bits.
// Top level; depends on stt_pkg, stt_front, stt_queue and stt_back.
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POS_WIDTH   = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_in  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out      o_data,
    input  wire logic i_stall
);

    logic  q_push;
    t_qent q_push_data;
    logic  q_full;
    logic  q_pop;
    t_qent q_head;
    logic  q_empty;

    stt_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    stt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_empty     (q_empty)
    );

    stt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // no write into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("result queue written while full");

    // eof always closes the results of its request
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_kind == RK_TOKEN && o_data.token_kind == K_EOF)
        |-> o_data.last)
        else $error("eof token not marked last");

    // a completed token always covers at least one byte
    a_token_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_kind == RK_TOKEN) |-> (o_data.end_pos != o_data.begin_pos))
        else $error("token end equals token start");

    // value bytes never carry an error
    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.result_kind == RK_VALUE) |-> (o_data.error_code == E_NONE))
        else $error("value byte with error code");

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// testbench for source_text_tokenizer: random and directed byte streams, a
// byte-level tokenizer model that predicts every value byte and token
// depends on stt_pkg and source_text_tokenizer
`default_nettype none

module tb_top;
    import stt_pkg::*;

    typedef enum logic [4:0] {
        LX_START, LX_COMMENT, LX_ID, LX_ID_US, LX_WHOLE, LX_FRAC_START, LX_FRAC,
        LX_EXP_START, LX_EXP_SIGN, LX_EXP, LX_STR, LX_STR_ESC, LX_OP, LX_DOT, LX_DOT2
    } t_lex_mode;

    typedef struct packed {
        logic drain_first;
        t_in  req;
    } t_send_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    t_send_item bytes_to_send [$];
    t_out       step_res [$];
    t_out       results_due [$];
    t_out       seen;
    t_send_item nxt;
    logic       hold_next = 1'b0;
    int         n_predicted = 0;
    int         n_checked = 0;
    int         mismatches = 0;
    int         cyc = 0;
    logic       calm;

    // tokenizer state
    t_lex_mode   lx_mode = LX_START;
    logic [2:0]  lx_op = '0;
    logic [31:0] lx_pos = '0;
    logic [31:0] lx_tok_start = '0;
    logic        lx_float = 1'b0;

    string op_spell [30] = '{"+", "-", "*", "/", "^", "(", ")", ",", ";", "[", "]", "{",
                             "}", ".", ":", "=", "==", "!", "!=", "<", "<=", ">", ">=",
                             "&", "&&", "|", "||", "->", "..", "..."};

    source_text_tokenizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // a long stretch where neither side idles at random
    assign calm = (cyc >= 800) && (cyc < 1600);

    function automatic void emit(logic rk, logic [7:0] vb, logic [5:0] tk, logic [2:0] ec,
                                 logic [31:0] s, logic [31:0] e);
        t_out r;
        r.result_kind = rk;
        r.value_byte  = vb;
        r.token_kind  = tk;
        r.error_code  = ec;
        r.begin_pos   = s;
        r.end_pos     = e;
        r.last        = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void close_token(logic [5:0] tk, logic [2:0] ec, logic [31:0] e);
        emit(RK_TOKEN, 8'h00, tk, ec, lx_tok_start, (e == lx_tok_start) ? e + 1 : e);
    endfunction

    function automatic void emit_byte(logic [7:0] b, logic [5:0] tk, logic [31:0] p);
        emit(RK_VALUE, b, tk, E_NONE, lx_tok_start, p + 1);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c[7];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [5:0] num_kind();
        return lx_float ? K_FLOAT : K_INT;
    endfunction

    function automatic int op_index(logic [7:0] c);
        case (c)
            "=": return 0;
            "!": return 1;
            "<": return 2;
            ">": return 3;
            "&": return 4;
            "|": return 5;
            "-": return 6;
            default: return -1;
        endcase
    endfunction

    function automatic logic [7:0] op_follow(logic [2:0] i);
        case (i)
            3'd4: return "&";
            3'd5: return "|";
            3'd6: return ">";
            default: return "=";
        endcase
    endfunction

    function automatic logic [5:0] op_long_kind(logic [2:0] i);
        case (i)
            3'd0: return K_EQ;
            3'd1: return K_NE;
            3'd2: return K_LE;
            3'd3: return K_GE;
            3'd4: return K_LAND;
            3'd5: return K_LOR;
            default: return K_ARROW;
        endcase
    endfunction

    function automatic logic [5:0] op_short_kind(logic [2:0] i);
        case (i)
            3'd0: return K_ASSIGN;
            3'd1: return K_NOT;
            3'd2: return K_LT;
            3'd3: return K_GT;
            3'd4: return K_AND;
            3'd5: return K_OR;
            default: return K_SUB;
        endcase
    endfunction

    // single-byte tokens; K_EOF stands for no such token
    function automatic logic [5:0] single_kind(logic [7:0] c);
        case (c)
            "+": return K_ADD;
            "*": return K_MUL;
            "/": return K_DIV;
            "^": return K_CARET;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "\n": return K_NEWLINE;
            ",": return K_COMMA;
            ";": return K_SEMI;
            "[": return K_LSQB;
            "]": return K_RSQB;
            "{": return K_LCURLY;
            "}": return K_RCURLY;
            ":": return K_COLON;
            default: return K_EOF;
        endcase
    endfunction

    function automatic void open_token(logic [7:0] c, logic [31:0] p);
        int         oi;
        logic [5:0] k;
        oi = op_index(c);
        k = single_kind(c);
        lx_mode = LX_START;
        lx_tok_start = p;
        if (oi >= 0) begin
            lx_mode = LX_OP;
            lx_op = oi[2:0];
        end else if (c == "#") begin
            lx_mode = LX_COMMENT;
        end else if (is_letter(c)) begin
            lx_mode = LX_ID;
            emit_byte(c, K_ID, p);
        end else if (c == "_") begin
            lx_mode = LX_ID_US;
            emit_byte(c, K_ID, p);
        end else if (is_digit(c)) begin
            lx_mode = LX_WHOLE;
            lx_float = 1'b0;
            emit_byte(c, K_INT, p);
        end else if (c == "\"") begin
            lx_mode = LX_STR;
        end else if (c == ".") begin
            lx_mode = LX_DOT;
        end else if (c == " " || c == "\t") begin
            // blanks are skipped
        end else if (k != K_EOF) begin
            close_token(k, E_NONE, p + 1);
        end else begin
            close_token(K_ERR, E_BAD_CHAR, p + 1);
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic [31:0] p);
        t_lex_mode m;
        m = lx_mode;
        case (m)
            LX_COMMENT: begin
                if (c == "\n") open_token(c, p);
                return;
            end
            LX_ID: begin
                if (is_letter(c) || is_digit(c) || c == "_") begin
                    emit_byte(c, K_ID, p);
                    return;
                end
                close_token(K_ID, E_NONE, p);
            end
            LX_ID_US: begin
                if (c == "_" || is_digit(c)) begin
                    close_token(K_ERR, E_UNDERSC, p + 1);
                    lx_mode = LX_START;
                    return;
                end
                if (is_letter(c)) begin
                    lx_mode = LX_ID;
                    emit_byte(c, K_ID, p);
                    return;
                end
                close_token(K_ID, E_NONE, p);
            end
            LX_WHOLE, LX_FRAC_START, LX_FRAC, LX_EXP_START, LX_EXP: begin
                if (is_digit(c)) begin
                    if (m == LX_FRAC_START) lx_mode = LX_FRAC;
                    else if (m == LX_EXP_START) lx_mode = LX_EXP;
                    emit_byte(c, num_kind(), p);
                    return;
                end
                if (m == LX_WHOLE && c == ".") begin
                    lx_mode = LX_FRAC_START;
                    lx_float = 1'b1;
                    emit_byte(c, K_FLOAT, p);
                    return;
                end
                if ((m == LX_WHOLE || m == LX_FRAC) && c == "e") begin
                    lx_mode = LX_EXP_START;
                    lx_float = 1'b1;
                    emit_byte(c, K_FLOAT, p);
                    return;
                end
                if (m == LX_EXP_START && (c == "+" || c == "-")) begin
                    lx_mode = LX_EXP_SIGN;
                    emit_byte(c, K_FLOAT, p);
                    return;
                end
                close_token(num_kind(), E_NONE, p);
            end
            LX_EXP_SIGN: begin
                if (is_digit(c)) begin
                    lx_mode = LX_EXP;
                    emit_byte(c, num_kind(), p);
                    return;
                end
                close_token(K_ERR, E_EXP_SIGN, p);
            end
            LX_STR: begin
                if (c == "\\") begin
                    lx_mode = LX_STR_ESC;
                end else if (c == "\"") begin
                    close_token(K_STR, E_NONE, p + 1);
                    lx_mode = LX_START;
                end else begin
                    emit_byte(c, K_STR, p);
                end
                return;
            end
            LX_STR_ESC: begin
                lx_mode = LX_STR;
                if (c == "\\") begin
                    emit_byte(8'h5C, K_STR, p);
                end else if (c == "n") begin
                    emit_byte(8'h0A, K_STR, p);
                end else if (c == "r") begin
                    emit_byte(8'h0D, K_STR, p);
                end else begin
                    close_token(K_ERR, E_ESCAPE, p + 1);
                    lx_mode = LX_START;
                end
                return;
            end
            LX_DOT: begin
                if (c == ".") begin
                    lx_mode = LX_DOT2;
                    return;
                end
                close_token(K_DOT, E_NONE, p);
            end
            LX_DOT2: begin
                if (c == ".") begin
                    close_token(K_ELLIPSIS, E_NONE, p + 1);
                    lx_mode = LX_START;
                    return;
                end
                close_token(K_RANGE, E_NONE, p);
            end
            LX_OP: begin
                if (c == op_follow(lx_op)) begin
                    close_token(op_long_kind(lx_op), E_NONE, p + 1);
                    lx_mode = LX_START;
                    return;
                end
                close_token(op_short_kind(lx_op), E_NONE, p);
            end
            default: begin
            end
        endcase
        // the byte that ended a token starts afresh
        open_token(c, p);
    endfunction

    function automatic void lex_flush(logic [31:0] p);
        case (lx_mode)
            LX_ID, LX_ID_US: close_token(K_ID, E_NONE, p);
            LX_EXP_SIGN: close_token(K_ERR, E_EXP_SIGN, p);
            LX_WHOLE, LX_FRAC_START, LX_FRAC, LX_EXP_START, LX_EXP:
                close_token(num_kind(), E_NONE, p);
            LX_STR, LX_STR_ESC: close_token(K_ERR, E_UNCLOSED, p);
            LX_OP: close_token(op_short_kind(lx_op), E_NONE, p);
            LX_DOT: close_token(K_DOT, E_NONE, p);
            LX_DOT2: close_token(K_RANGE, E_NONE, p);
            default: begin
            end
        endcase
    endfunction

    // advances the tokenizer by one request, queues its results, returns their count
    function automatic int tokenize_request(t_in r);
        logic [31:0] p;
        int          n;
        p = lx_pos;
        step_res.delete();
        if (r.end_of_input) begin
            lex_flush(p);
            lx_mode = LX_START;
            emit(RK_TOKEN, 8'h00, K_EOF, E_NONE, p, p + 1);
        end else begin
            lex_byte(r.ch, p);
            lx_pos = p + 1;
        end
        n = step_res.size();
        if (n > 0) step_res[n-1].last = 1'b1;
        foreach (step_res[i]) results_due.push_back(step_res[i]);
        return n;
    endfunction

    task automatic push_req(t_in r);
        t_send_item it;
        it.drain_first = hold_next;
        it.req = r;
        hold_next = 1'b0;
        bytes_to_send.push_back(it);
    endtask

    task automatic push_byte(logic [7:0] b);
        t_in r;
        r.ch = b;
        r.end_of_input = 1'b0;
        push_req(r);
    endtask

    task automatic push_end();
        t_in r;
        r.ch = 8'($urandom_range(0, 255));
        r.end_of_input = 1'b1;
        push_req(r);
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 2))
            0: return "a" + 8'($urandom_range(0, 25));
            1: return "A" + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_digit();
        return "0" + 8'($urandom_range(0, 9));
    endfunction

    // one token-shaped piece of text, mostly well formed
    task automatic push_fragment();
        int         pick;
        int         n;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            if ($urandom_range(0, 4) == 0) push_byte("_");
            n = $urandom_range(1, 6);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    5, 6: push_byte(rand_digit());
                    7: push_byte("_");
                    default: push_byte(rand_letter());
                endcase
            end
        end else if (pick < 40) begin
            repeat ($urandom_range(1, 4)) push_byte(rand_digit());
            if ($urandom_range(0, 2) == 0) begin
                push_byte(".");
                repeat ($urandom_range(0, 3)) push_byte(rand_digit());
            end
            if ($urandom_range(0, 2) == 0) begin
                push_byte("e");
                if ($urandom_range(0, 1) == 0) push_byte($urandom_range(0, 1) ? "+" : "-");
                repeat ($urandom_range(0, 3)) push_byte(rand_digit());
            end
        end else if (pick < 52) begin
            push_byte("\"");
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 5) == 0) begin
                    push_byte("\\");
                    case ($urandom_range(0, 3))
                        0: push_byte("\\");
                        1: push_byte("n");
                        2: push_byte("r");
                        default: push_byte(8'($urandom_range(0, 255)));
                    endcase
                end else begin
                    push_byte(" " + 8'($urandom_range(0, 94)));
                end
            end
            if ($urandom_range(0, 9) != 0) push_byte("\"");
        end else if (pick < 75) begin
            push_text(op_spell[$urandom_range(0, 29)]);
        end else if (pick < 83) begin
            case ($urandom_range(0, 2))
                0: push_byte(" ");
                1: push_byte("\t");
                default: push_byte("\n");
            endcase
        end else if (pick < 88) begin
            push_byte("#");
            repeat ($urandom_range(0, 5)) begin
                b = 8'($urandom_range(0, 255));
                push_byte((b == "\n") ? "x" : b);
            end
            push_byte("\n");
        end else if (pick < 97) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_end();
        end
        if ($urandom_range(0, 1) == 0) push_byte(" ");
    endtask

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) n_predicted <= n_predicted + tokenize_request(i_data);
            if (!i_valid || !o_stall) begin
                if (bytes_to_send.size() != 0 && bytes_to_send[0].drain_first &&
                    (i_valid || n_predicted != n_checked)) begin
                    i_valid <= 1'b0;
                end else if (bytes_to_send.size() != 0 &&
                             (calm || $urandom_range(0, 99) >= 33)) begin
                    nxt = bytes_to_send.pop_front();
                    i_data <= nxt.req;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (results_due.size() == 0) begin
                    $error("result_kind: expected none, got %0d", o_data.result_kind);
                    mismatches++;
                end else begin
                    seen = results_due.pop_front();
                    check_field("result_kind", 32'(seen.result_kind),
                                32'(o_data.result_kind));
                    check_field("value_byte", 32'(seen.value_byte), 32'(o_data.value_byte));
                    check_field("token_kind", 32'(seen.token_kind), 32'(o_data.token_kind));
                    check_field("error_code", 32'(seen.error_code), 32'(o_data.error_code));
                    check_field("begin_pos", seen.begin_pos, o_data.begin_pos);
                    check_field("end_pos", seen.end_pos, o_data.end_pos);
                    check_field("last", 32'(seen.last), 32'(o_data.last));
                end
                n_checked <= n_checked + 1;
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 33);
        end
    end

    initial begin
        int pause_at;
        pause_at = 400;
        // directed: underscore error, exponent sign error, escapes and a bad escape,
        // ellipsis, carriage return, comment ended by newline, byte extremes,
        // float ending in a dot flushed at end, unclosed string at end
        push_text("_1 1e+q\"a\\n\\z...");
        push_byte(8'h0D);
        push_text("#c\n");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_text("1.");
        push_end();
        push_text("\"a");
        push_end();
        while (bytes_to_send.size() < 1100) begin
            if (bytes_to_send.size() > pause_at) begin
                hold_next = 1'b1;
                pause_at += 400;
            end
            push_fragment();
        end
        push_end();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (bytes_to_send.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (n_checked < n_predicted) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (results_due.size() != 0)
            $error("result_kind: expected %0d more results, got none", results_due.size());
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
